FILE: design/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg
// Types and codes shared by the timeout counter pool controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package tcp_pkg;

  // Operation codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_SET     = 3'd4;

  // Input beat
  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  counter_handle;
    logic [15:0] tick_count;
  } tcp_in_t;

  // Output beat
  typedef struct packed {
    logic [4:0]  handle_out;
    logic        success;
    logic [15:0] counter_value;
    logic        is_expired;
  } tcp_out_t;

  // Controller states
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_TICK_RD = 8'b0000_0100,
    S_TICK_WR = 8'b0000_1000,
    S_ALLOC   = 8'b0001_0000,
    S_ACC_RD  = 8'b0010_0000,
    S_ACC_WR  = 8'b0100_0000,
    S_RESULT  = 8'b1000_0000
  } tcp_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // take the input beat, clear index and result
    logic sel_handle;  // address the counter named by the handle
    logic idx_inc;     // step the walk index
    logic tick_wr;     // write back the decremented counter
    logic alloc_chk;   // claim the slot at the index if it is free
    logic acc_wr;      // finish release, query or set
    logic mark_exp;    // no-handle answer
    logic out_load;    // move the result into the output register
  } tcp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       handle_ok;
    logic       idx_last;
    logic       cur_free;
    logic       out_free;
  } tcp_status_t;

endpackage

FILE: design/timeout_counter_pool.sv
// ----------------------------------------------------------------------------
// timeout_counter_pool
// Pool of down-counting timeout counters with handle allocation.
// ----------------------------------------------------------------------------
// One operation is taken at a time and each gives exactly one output beat.
// Counters live in a single-port memory with registered read, so tick,
// release, query and set read a counter in a read state before a write
// state acts on it. Tick walks every counter, allocate scans the free flags
// one per cycle and stops at the lowest free slot or at the last slot,
// release, query and set touch only the counter named by the handle, and
// no-handle and unknown operations touch no counter. A finished result sits
// in the output register, and the next beat is accepted while it waits;
// work stalls only when a new result is ready and the previous one has not
// been taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module timeout_counter_pool #(
  parameter int NUM_COUNTERS = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcp_pkg::tcp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcp_pkg::tcp_out_t out_data
);
  import tcp_pkg::*;

  tcp_cmd_t    cmd;
  tcp_status_t status;

  // Sequencer
  tcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and result path
  tcp_datapath #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: design/tcp_ctrl.sv
// ----------------------------------------------------------------------------
// tcp_ctrl
// Sequencer for the timeout counter pool: decodes the operation and walks
// the counters for tick and allocate.
// ----------------------------------------------------------------------------
module tcp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcp_pkg::tcp_status_t status,
  output tcp_pkg::tcp_cmd_t    cmd
);
  import tcp_pkg::*;

  tcp_state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          OP_TICK:  state_next = S_TICK_RD;
          OP_ALLOC: state_next = S_ALLOC;
          OP_RELEASE, OP_QUERY, OP_SET: begin
            if (status.handle_ok) begin
              state_next = S_ACC_RD;
            end else begin
              cmd.mark_exp = 1'b1;
              state_next   = S_RESULT;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_TICK_RD: state_next = S_TICK_WR;
      S_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        if (status.idx_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_TICK_RD;
        end
      end
      S_ALLOC: begin
        cmd.alloc_chk = 1'b1;
        if (status.cur_free || status.idx_last) begin
          state_next = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_ACC_RD: begin
        cmd.sel_handle = 1'b1;
        state_next     = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd.sel_handle = 1'b1;
        cmd.acc_wr     = 1'b1;
        state_next     = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A finished result waits while the output register is held
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && !status.out_free) |=> (state == S_RESULT))
    else $error("result dropped while output stalled");

  // Counter access only for a handle inside the pool
  a_acc_handle: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC_RD) |-> status.handle_ok)
    else $error("counter access with no handle");

endmodule

FILE: design/tcp_datapath.sv
// ----------------------------------------------------------------------------
// tcp_datapath
// Counter memory, free and written flags, walk index, result staging and
// the output register of the timeout counter pool.
// ----------------------------------------------------------------------------
module tcp_datapath #(
  parameter int NUM_COUNTERS = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcp_pkg::tcp_in_t     in_data,
  input  tcp_pkg::tcp_cmd_t    cmd,
  output tcp_pkg::tcp_status_t status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output tcp_pkg::tcp_out_t    out_data
);
  import tcp_pkg::*;

  localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam logic [4:0] NO_HANDLE = 5'(NUM_COUNTERS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_COUNTERS - 1);

  // Captured operation
  logic [2:0]             op_q;
  logic [4:0]             handle_q;
  logic [COUNT_WIDTH-1:0] load_q;

  // Walk index and counter address
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] addr;

  // Counter storage: entries never written since reset read as zero
  logic [COUNT_WIDTH-1:0] mem [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] written;
  logic [NUM_COUNTERS-1:0] slot_free;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_written;
  logic [COUNT_WIDTH-1:0] cur_val;

  // Write port
  logic                   we;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   alloc_hit;
  logic                   rel_hit;
  logic [COUNT_WIDTH-1:0] load_nz;

  // Result staging
  logic [4:0]  res_hout;
  logic        res_ok;
  logic [15:0] res_val;
  logic        res_exp;

  assign addr      = cmd.sel_handle ? IDX_W'(handle_q) : idx;
  assign cur_val   = rd_written ? rd_data : '0;
  assign load_nz   = (load_q == '0) ? COUNT_WIDTH'(1) : load_q;
  assign alloc_hit = cmd.alloc_chk && slot_free[addr];
  assign rel_hit   = cmd.acc_wr && (op_q == OP_RELEASE);

  assign status.op        = op_q;
  assign status.handle_ok = (32'(handle_q) < NUM_COUNTERS);
  assign status.idx_last  = (idx == IDX_LAST);
  assign status.cur_free  = slot_free[addr];
  assign status.out_free  = !out_valid || !out_stall;

  // Write data select
  always_comb begin
    we    = 1'b0;
    wdata = '0;
    if (cmd.tick_wr) begin
      we    = (cur_val != '0);
      wdata = cur_val - COUNT_WIDTH'(1);
    end else if (alloc_hit) begin
      we    = 1'b1;
      wdata = load_nz;
    end else if (cmd.acc_wr && op_q == OP_SET) begin
      we    = 1'b1;
      wdata = load_q;
    end
  end

  // Captured fields and walk index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= in_data.operation;
      handle_q <= in_data.counter_handle;
      load_q   <= COUNT_WIDTH'(in_data.tick_count);
    end
    if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Counter memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  // Written and free flags
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      slot_free  <= '1;
      rd_written <= 1'b0;
    end else begin
      rd_written <= written[addr];
      if (we) begin
        written[addr] <= 1'b1;
      end else if (rel_hit) begin
        written[addr] <= 1'b0;
      end
      if (alloc_hit) begin
        slot_free[addr] <= 1'b0;
      end else if (rel_hit) begin
        slot_free[addr] <= 1'b1;
      end
    end
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_hout <= NO_HANDLE;
      res_ok   <= 1'b0;
      res_val  <= '0;
      res_exp  <= 1'b0;
    end else begin
      if (cmd.mark_exp) begin
        res_exp <= 1'b1;
      end
      if (alloc_hit) begin
        res_hout <= 5'(addr);
        res_ok   <= 1'b1;
      end
      if (cmd.acc_wr) begin
        case (op_q)
          OP_QUERY: begin
            res_val <= 16'(cur_val);
            res_exp <= (cur_val == '0);
          end
          OP_SET:  res_val <= 16'(cur_val);
          default: res_val <= '0;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.handle_out    <= res_hout;
      out_data.success       <= res_ok;
      out_data.counter_value <= res_val;
      out_data.is_expired    <= res_exp;
    end
  end

  // A result never overwrites a beat still waiting on the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output beat overwritten");

  // A claimed slot is no longer free
  a_alloc_claims: assert property (@(posedge clk) disable iff (rst)
    alloc_hit |=> !slot_free[$past(addr)])
    else $error("allocated slot still free");

  // Success always comes with a handle inside the pool
  a_success_handle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.success) |-> (32'(out_data.handle_out) < NUM_COUNTERS))
    else $error("success with handle outside pool");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timeout counter pool. A short table of
// directed beats covers reset state, load extremes, zero loads, missing and
// unclaimed handles and unknown opcodes. Random beats follow, grouped into
// grow and shrink phases. Every accepted beat runs through a shadow model of
// the pool, and output beats are checked in order against its answers.
// ----------------------------------------------------------------------------
module tb_top;
  import tcp_pkg::*;

  localparam int          POOL_SIZE     = 16;
  localparam int          SLOT_W        = $clog2(POOL_SIZE);
  localparam logic [4:0]  NO_HANDLE     = 5'd16;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;
  localparam int          RANDOM_ITEMS  = 1410;
  localparam int          TAIL_ITEMS    = 200;
  localparam int          HOLD_SPAN     = 300;
  localparam int          DRAIN_CYCLES  = 60;
  localparam int          CYCLE_LIMIT   = 500000;

  typedef enum int {MIX_GROW, MIX_SHRINK} mix_t;

  typedef struct {
    tcp_in_t  beat;
    bit       typed;
    tcp_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  tcp_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tcp_out_t out_data;

  // Shadow copy of the pool
  logic [15:0] ticks_left [POOL_SIZE] = '{default: '0};
  bit          slot_open  [POOL_SIZE] = '{default: 1'b1};

  tcp_out_t pending_answers [$];
  int       mismatches  = 0;
  int       cycle_count = 0;
  int       gap_pct     = 20;
  int       stall_pct   = 20;
  bit       hold_req    = 1'b0;

  // Directed beats; rows with typed set carry an answer read straight off
  // the spec, the rest are checked against the shadow model.
  dir_row_t dir_rows [25] = '{
    // reset state: counter zero, expired
    '{'{OP_QUERY,   5'd0,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    // tick on an all-zero pool stays at zero
    '{'{OP_TICK,    5'd3,  16'hFFFF}, 1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    // allocate with a zero load gets one
    '{'{OP_ALLOC,   5'd31, 16'd0},    1'b1, '{5'd0,      1'b1, 16'd0,    1'b0}},
    '{'{OP_QUERY,   5'd0,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd1,    1'b0}},
    '{'{OP_TICK,    5'd0,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    '{'{OP_QUERY,   5'd0,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    // full-scale load, then set with zero expires at once
    '{'{OP_ALLOC,   5'd0,  16'hFFFF}, 1'b1, '{5'd1,      1'b1, 16'd0,    1'b0}},
    '{'{OP_SET,     5'd1,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'hFFFF, 1'b0}},
    '{'{OP_QUERY,   5'd1,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    '{'{OP_SET,     5'd1,  16'hFFFF}, 1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    '{'{OP_TICK,    5'd1,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    '{'{OP_QUERY,   5'd1,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'hFFFE, 1'b0}},
    // release zeroes and frees
    '{'{OP_RELEASE, 5'd1,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    '{'{OP_QUERY,   5'd1,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    // missing handle on release, query and set
    '{'{OP_RELEASE, 5'd16, 16'd5},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    '{'{OP_QUERY,   5'd31, 16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    '{'{OP_SET,     5'd31, 16'd1234}, 1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    // unclaimed counters are still touched
    '{'{OP_QUERY,   5'd5,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b1}},
    '{'{OP_SET,     5'd5,  16'd7},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    '{'{OP_RELEASE, 5'd9,  16'd0},    1'b1, '{NO_HANDLE, 1'b0, 16'd0,    1'b0}},
    // allocate ignores the handle and reuses the freed slot
    '{'{OP_ALLOC,   5'd31, 16'd9},    1'b1, '{5'd1,      1'b1, 16'd0,    1'b0}},
    // unknown opcodes
    '{'{OP_RSVD_FIRST, 5'd2,  16'd5},    1'b1, '{NO_HANDLE, 1'b0, 16'd0, 1'b0}},
    '{'{OP_RSVD_LAST,  5'd31, 16'hFFFF}, 1'b1, '{NO_HANDLE, 1'b0, 16'd0, 1'b0}},
    '{'{OP_QUERY,   5'd5,  16'd0},    1'b0, '0},
    '{'{OP_TICK,    5'd7,  16'h8000}, 1'b0, '0}
  };

  timeout_counter_pool #(
    .NUM_COUNTERS (POOL_SIZE),
    .COUNT_WIDTH  (16)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow model: apply one beat to the pool and return its answer
  function automatic tcp_out_t pool_step(tcp_in_t b);
    tcp_out_t          r;
    logic [15:0]       load;
    logic [SLOT_W-1:0] slot;
    bit                found;
    int                i;
    r     = '{NO_HANDLE, 1'b0, 16'd0, 1'b0};
    load  = b.tick_count;
    slot  = SLOT_W'(b.counter_handle);
    found = 1'b0;
    case (b.operation)
      OP_TICK: begin
        for (i = 0; i < POOL_SIZE; i++)
          if (ticks_left[SLOT_W'(i)] != 16'd0)
            ticks_left[SLOT_W'(i)] = ticks_left[SLOT_W'(i)] - 16'd1;
      end
      OP_ALLOC: begin
        if (load == 16'd0) load = 16'd1;
        for (i = 0; i < POOL_SIZE; i++) begin
          if (!found && slot_open[SLOT_W'(i)]) begin
            found                  = 1'b1;
            slot_open[SLOT_W'(i)]  = 1'b0;
            ticks_left[SLOT_W'(i)] = load;
            r.handle_out           = 5'(i);
            r.success              = 1'b1;
          end
        end
      end
      OP_RELEASE, OP_QUERY, OP_SET: begin
        if (b.counter_handle >= NO_HANDLE) begin
          r.is_expired = 1'b1;
        end else if (b.operation == OP_RELEASE) begin
          ticks_left[slot] = 16'd0;
          slot_open[slot]  = 1'b1;
        end else if (b.operation == OP_QUERY) begin
          r.counter_value = ticks_left[slot];
          r.is_expired    = (r.counter_value == 16'd0);
        end else begin
          r.counter_value  = ticks_left[slot];
          ticks_left[slot] = load;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly claimed handles, some unclaimed, some out of range
  function automatic logic [4:0] pick_handle();
    int roll, start, k;
    roll  = $urandom_range(0, 99);
    start = $urandom_range(0, POOL_SIZE - 1);
    if (roll < 10) return 5'($urandom_range(POOL_SIZE, 31));
    if (roll < 20) return 5'(start);
    for (k = 0; k < POOL_SIZE; k++)
      if (!slot_open[SLOT_W'((start + k) % POOL_SIZE)]) return 5'((start + k) % POOL_SIZE);
    return 5'(start);
  endfunction

  // Short loads so ticks actually expire counters, plus extremes
  function automatic logic [15:0] pick_ticks();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 16'($urandom_range(1, 6));
    if (roll < 60) return 16'd0;
    if (roll < 70) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic tcp_in_t pick_beat(mix_t mix);
    tcp_in_t b;
    int      roll;
    b.counter_handle = pick_handle();
    b.tick_count     = pick_ticks();
    roll             = $urandom_range(0, 99);
    if (roll < 4)                 b.operation = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    else if (mix == MIX_GROW) begin
      if (roll < 45)              b.operation = OP_ALLOC;
      else if (roll < 62)         b.operation = OP_TICK;
      else if (roll < 78)         b.operation = OP_QUERY;
      else if (roll < 90)         b.operation = OP_SET;
      else                        b.operation = OP_RELEASE;
    end else begin
      if (roll < 40)              b.operation = OP_RELEASE;
      else if (roll < 60)         b.operation = OP_TICK;
      else if (roll < 80)         b.operation = OP_QUERY;
      else if (roll < 92)         b.operation = OP_SET;
      else                        b.operation = OP_ALLOC;
    end
    return b;
  endfunction

  // Offer one beat, hold it until taken, then log its answer
  task automatic send_beat(tcp_in_t b, bit typed, tcp_out_t want);
    tcp_out_t got;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    got = pool_step(b);
    pending_answers.push_back(typed ? want : got);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Output side: compare each taken beat with the oldest answer
  always @(posedge clk) begin : answer_check
    tcp_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("output beat with no answer pending");
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        check_field("handle_out", want.handle_out, out_data.handle_out);
        check_field("success", want.success, out_data.success);
        check_field("counter_value", want.counter_value, out_data.counter_value);
        check_field("is_expired", want.is_expired, out_data.is_expired);
      end
    end
  end

  // Receiver: short random stalls, one long hold on request
  initial begin : drain_side
    int held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_SPAN; held++) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin : feed_side
    int   n;
    int   phase_left;
    mix_t mix;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    phase_left = 0;
    mix        = MIX_SHRINK;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n])
      send_beat(dir_rows[n].beat, dir_rows[n].typed, dir_rows[n].want);

    // fill the pool and run past full
    repeat (POOL_SIZE + 2)
      send_beat('{OP_ALLOC, pick_handle(), pick_ticks()}, 1'b0, '0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // new phase: flip the mix, reshuffle idling
      if (phase_left == 0) begin
        mix        = (mix == MIX_GROW) ? MIX_SHRINK : MIX_GROW;
        phase_left = $urandom_range(60, 150);
        if (n < RANDOM_ITEMS - TAIL_ITEMS) begin
          gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 20;
          stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
        end
      end
      phase_left--;
      if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      // long receiver hold while beats keep coming
      if (n == 300) hold_req = 1'b1;
      // sender waits out every pending answer
      if (n == 700) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
      end
      send_beat(pick_beat(mix), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
